### hw/rtl/ready_queue_fifo_or_priority_defines.svh
// Assertion macros for the ready queue checker.
// Depends on nothing; included by the checker file.
`ifndef READY_QUEUE_FIFO_OR_PRIORITY_DEFINES_SVH
`define READY_QUEUE_FIFO_OR_PRIORITY_DEFINES_SVH

// Check a property on the rising clock edge, disabled during reset.
`define RQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on the rising clock edge, reset included.
`define RQ_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/rq_pkg.sv
// Types and constants of the ready queue.
// No dependencies; used by ready_queue_fifo_or_priority and rq_chk.
`default_nettype none

package rq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned IdW        = 8;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned OccW       = 5;
  localparam int unsigned EntryW     = IdW + PrioW;

  typedef enum logic {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIFO_RD,
    S_SCAN,
    S_SHIFT
  } state_e;

  typedef struct packed {
    req_e             req_type;
    logic [IdW-1:0]   thread_id;
    logic [PrioW-1:0] thread_priority;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   chosen_id;
    logic [PrioW-1:0] chosen_priority;
    logic [OccW-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } entry_t;

endpackage

`default_nettype wire

### hw/rtl/ready_queue_fifo_or_priority.sv
// Ready queue of thread entries with FIFO or highest-priority dequeue.
// Depends on rq_pkg and rq_ram.
//
//   channel   | signals                         | handshake
//   ----------+---------------------------------+--------------------------
//   request   | req_i (rq_pkg::req_t)           | start high, busy low
//   result    | rsp_o (rq_pkg::rsp_t)           | done_o, one cycle, no stall
//   config    | cfg_wdata_i (priority_mode)     | cfg_we_i
//
// Enqueue and empty dequeue: result registered from the idle state; FIFO-mode dequeue: via S_FIFO_RD.
// Priority dequeue: the entries are scanned through the single RAM read port,
// then the entries younger than the winner are moved down one slot.
// Reset empties the queue at once; there is no clearing pass.
`default_nettype none

module ready_queue_fifo_or_priority (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire rq_pkg::req_t  req_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  output logic               done_o,
  output rq_pkg::rsp_t       rsp_o
);

  rq_pkg::state_e               state_q, state_d;
  logic [rq_pkg::IdxW-1:0]      head_q, head_d;
  logic [rq_pkg::CntW-1:0]      count_q, count_d;
  logic [rq_pkg::IdxW-1:0]      rd_off_q, rd_off_d;
  logic [rq_pkg::IdxW-1:0]      best_off_q, best_off_d;
  rq_pkg::entry_t               best_q, best_d;
  logic                         mode_q;
  logic                         done_q, done_d;
  rq_pkg::rsp_t                 rsp_q, rsp_d;

  logic                         ram_we, ram_re;
  logic [rq_pkg::IdxW-1:0]      ram_waddr, ram_raddr;
  rq_pkg::entry_t               ram_wdata, ram_rdata;

  logic                         accept, full, empty;
  logic                         scan_last, take_new, shift_none;
  rq_pkg::entry_t               scan_best;
  logic [rq_pkg::IdxW-1:0]      scan_best_off;
  logic [rq_pkg::CntW-1:0]      count_dec;

  function automatic logic [rq_pkg::IdxW-1:0] wrap_add(
    input logic [rq_pkg::IdxW-1:0] base,
    input logic [rq_pkg::IdxW-1:0] off
  );
    logic [rq_pkg::IdxW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (rq_pkg::IdxW+1)'(rq_pkg::QueueDepth)) begin
      sum = sum - (rq_pkg::IdxW+1)'(rq_pkg::QueueDepth);
    end
    return sum[rq_pkg::IdxW-1:0];
  endfunction

  rq_ram #(
    .Width (rq_pkg::EntryW),
    .Depth (rq_pkg::QueueDepth)
  ) u_rq_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy      = (state_q != rq_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign full      = (count_q == rq_pkg::CntW'(rq_pkg::QueueDepth));
  assign empty     = (count_q == '0);
  assign count_dec = count_q - rq_pkg::CntW'(1);

  assign scan_last     = ((rq_pkg::CntW'(rd_off_q) + rq_pkg::CntW'(1)) == count_q);
  assign take_new      = (rd_off_q == '0) || (ram_rdata.prio > best_q.prio);
  assign scan_best     = take_new ? ram_rdata : best_q;
  assign scan_best_off = take_new ? rd_off_q : best_off_q;
  assign shift_none    = ((rq_pkg::CntW'(scan_best_off) + rq_pkg::CntW'(1)) == count_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      rq_pkg::S_IDLE: begin
        if (accept && req_i.req_type == rq_pkg::REQ_DEQ && !empty) begin
          state_d = mode_q ? rq_pkg::S_SCAN : rq_pkg::S_FIFO_RD;
        end
      end
      rq_pkg::S_FIFO_RD: begin
        state_d = rq_pkg::S_IDLE;
      end
      rq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = shift_none ? rq_pkg::S_IDLE : rq_pkg::S_SHIFT;
        end
      end
      rq_pkg::S_SHIFT: begin
        if (scan_last) begin
          state_d = rq_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = rq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    rd_off_d   = rd_off_q;
    best_d     = best_q;
    best_off_d = best_off_q;
    done_d     = 1'b0;
    rsp_d      = rsp_q;
    ram_we     = 1'b0;
    ram_waddr  = wrap_add(head_q, rq_pkg::IdxW'(count_q));
    ram_wdata  = '{id: req_i.thread_id, prio: req_i.thread_priority};
    ram_re     = 1'b0;
    ram_raddr  = head_q;
    case (state_q)
      rq_pkg::S_IDLE: begin
        if (accept) begin
          if (req_i.req_type == rq_pkg::REQ_ENQ) begin
            done_d = 1'b1;
            if (full) begin
              rsp_d = '{status: rq_pkg::ST_FULL, chosen_id: '0, chosen_priority: '0,
                        occupancy: rq_pkg::OccW'(count_q)};
            end else begin
              ram_we  = 1'b1;
              count_d = count_q + rq_pkg::CntW'(1);
              rsp_d   = '{status: rq_pkg::ST_OK, chosen_id: '0, chosen_priority: '0,
                          occupancy: rq_pkg::OccW'(count_q + rq_pkg::CntW'(1))};
            end
          end else if (empty) begin
            done_d = 1'b1;
            rsp_d  = '{status: rq_pkg::ST_EMPTY, chosen_id: '0, chosen_priority: '0,
                       occupancy: '0};
          end else begin
            ram_re   = 1'b1;
            rd_off_d = '0;
          end
        end
      end
      rq_pkg::S_FIFO_RD: begin
        done_d  = 1'b1;
        head_d  = wrap_add(head_q, rq_pkg::IdxW'(1));
        count_d = count_dec;
        rsp_d   = '{status: rq_pkg::ST_OK, chosen_id: ram_rdata.id,
                    chosen_priority: ram_rdata.prio, occupancy: rq_pkg::OccW'(count_dec)};
      end
      rq_pkg::S_SCAN: begin
        best_d     = scan_best;
        best_off_d = scan_best_off;
        if (!scan_last) begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head_q, rd_off_q + rq_pkg::IdxW'(1));
          rd_off_d  = rd_off_q + rq_pkg::IdxW'(1);
        end else if (shift_none) begin
          done_d  = 1'b1;
          count_d = count_dec;
          rsp_d   = '{status: rq_pkg::ST_OK, chosen_id: scan_best.id,
                      chosen_priority: scan_best.prio, occupancy: rq_pkg::OccW'(count_dec)};
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head_q, scan_best_off + rq_pkg::IdxW'(1));
          rd_off_d  = scan_best_off + rq_pkg::IdxW'(1);
        end
      end
      rq_pkg::S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(head_q, rd_off_q - rq_pkg::IdxW'(1));
        ram_wdata = ram_rdata;
        if (scan_last) begin
          done_d  = 1'b1;
          count_d = count_dec;
          rsp_d   = '{status: rq_pkg::ST_OK, chosen_id: best_q.id,
                      chosen_priority: best_q.prio, occupancy: rq_pkg::OccW'(count_dec)};
        end else begin
          ram_re    = 1'b1;
          ram_raddr = wrap_add(head_q, rd_off_q + rq_pkg::IdxW'(1));
          rd_off_d  = rd_off_q + rq_pkg::IdxW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rq_pkg::S_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      rd_off_q <= '0;
      mode_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      rd_off_q <= rd_off_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_off_q <= best_off_d;
    rsp_q      <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

### hw/rtl/rq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rq_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                              wdata_i,
  input  wire logic                                          re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rq_chk.sv
// Port-level checker for the ready queue, bound to the top level.
// Depends on rq_pkg and ready_queue_fifo_or_priority_defines.svh.
`default_nettype none

`include "ready_queue_fifo_or_priority_defines.svh"

module rq_chk (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         start,
  input wire logic         busy,
  input wire logic         done_o,
  input wire rq_pkg::rsp_t rsp_o
);

  `RQ_ASSERT(a_occ_bound, clk_i, rst_ni,
    done_o |-> rsp_o.occupancy <= rq_pkg::OccW'(rq_pkg::QueueDepth),
    "occupancy above queue depth")
  `RQ_ASSERT(a_empty_rsp, clk_i, rst_ni,
    (done_o && rsp_o.status == rq_pkg::ST_EMPTY) |->
      (rsp_o.occupancy == '0 && rsp_o.chosen_id == '0 && rsp_o.chosen_priority == '0),
    "empty result not cleared")
  `RQ_ASSERT(a_full_rsp, clk_i, rst_ni,
    (done_o && rsp_o.status == rq_pkg::ST_FULL) |->
      (rsp_o.occupancy == rq_pkg::OccW'(rq_pkg::QueueDepth) && rsp_o.chosen_id == '0),
    "full result with wrong fields")
  `RQ_ASSERT(a_xfer_progress, clk_i, rst_ni,
    (start && !busy) |=> (busy || done_o),
    "accepted transfer made no progress")
  `RQ_ASSERT_ALWAYS(a_reset_quiet, clk_i,
    !rst_ni |=> (!busy && !done_o),
    "busy or done during reset")

endmodule

bind ready_queue_fifo_or_priority rq_chk u_rq_chk (.*);

`default_nettype wire
